// ===== hw/rtl/spc_pkg.sv =====
// ---------------------------------------------------------------------------
// Sphere pair contact force package
// Shared widths, beat types and status codes for the contact force pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

    localparam int COORD_W = 32;
    localparam int PARAM_W = 31;
    localparam int FORCE_W = 48;
    localparam int DIST_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * DIST_W;
    localparam int RSUM_W  = PARAM_W + 1;
    localparam int KSUM_W  = PARAM_W + 1;
    localparam int OVL_W   = PARAM_W + 1;
    localparam int PROD_W  = KSUM_W + OVL_W;

    localparam logic [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W - 1){1'b1}}};
    localparam logic [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W - 1){1'b0}}};

    typedef enum logic [1:0] {
        ST_NONE       = 2'd0,
        ST_CONTACT    = 2'd1,
        ST_COINCIDENT = 2'd2
    } contact_status_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_pos_x;
        logic signed [COORD_W-1:0] a_pos_y;
        logic signed [COORD_W-1:0] a_pos_z;
        logic signed [COORD_W-1:0] b_pos_x;
        logic signed [COORD_W-1:0] b_pos_y;
        logic signed [COORD_W-1:0] b_pos_z;
        logic [PARAM_W-1:0]        a_radius;
        logic [PARAM_W-1:0]        b_radius;
        logic [PARAM_W-1:0]        a_stiffness;
        logic [PARAM_W-1:0]        b_stiffness;
    } pair_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic signed [FORCE_W-1:0] force_z;
        contact_status_t           contact_status;
        logic                      saturated;
    } result_t;

    typedef struct packed {
        logic [2:0]              neg;
        logic [2:0][DIST_W-1:0]  mag;
        logic [RSUM_W-1:0]       rsum;
        logic [KSUM_W-1:0]       ksum;
    } geo_side_t;

    typedef struct packed {
        logic [2:0]      neg;
        contact_status_t status;
    } div_side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spc_sqrt.sv =====
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Restoring square root, one root bit per register stage, with a sideband.
// ---------------------------------------------------------------------------
`default_nettype none

module spc_sqrt
    import spc_pkg::*;
#(
    parameter int SB_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SQ_W-1:0]   in_sq,
    input  logic [SB_W-1:0]   in_sb,
    output logic              out_valid,
    output logic [DIST_W-1:0] out_root,
    output logic [SB_W-1:0]   out_sb
);

    logic [DIST_W-1:0] valid_reg;
    logic [SQ_W-1:0]   rem_reg  [DIST_W];
    logic [DIST_W-1:0] root_reg [DIST_W];
    logic [SB_W-1:0]   sb_reg   [DIST_W];

    for (genvar k = 0; k < DIST_W; k++)
    begin : g_step
        localparam int B = DIST_W - 1 - k;

        logic              v_in;
        logic [SQ_W-1:0]   rem_in;
        logic [SQ_W-1:0]   trial;
        logic [SQ_W-1:0]   rem_next;
        logic [DIST_W-1:0] root_in;
        logic [DIST_W-1:0] root_next;
        logic [SB_W-1:0]   sb_in;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_sq;
            assign root_in = '0;
            assign sb_in   = in_sb;
        end
        else
        begin : g_later
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign sb_in   = sb_reg[k-1];
        end

        assign trial = (SQ_W'(root_in) << (B + 1)) | (SQ_W'(1) << (2 * B));

        always_comb
        begin
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (DIST_W'(1) << B);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                sb_reg[k]   <= sb_in;
            end
        end
    end

    assign out_valid = valid_reg[DIST_W-1];
    assign out_root  = root_reg[DIST_W-1];
    assign out_sb    = sb_reg[DIST_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/spc_div.sv =====
// ---------------------------------------------------------------------------
// Pipelined three lane divider
// Restoring division of three numerators by one shared divisor, one quotient
// bit per register stage, with a sideband.
// ---------------------------------------------------------------------------
`default_nettype none

module spc_div
    import spc_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int SB_W = 1,
    localparam int NUM_W = PROD_W + DIST_W - FRAC_BITS - 1,
    localparam int QUO_W = PROD_W - FRAC_BITS - 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2:0][NUM_W-1:0] in_num,
    input  logic [DIST_W-1:0]     in_den,
    input  logic [SB_W-1:0]       in_sb,
    output logic                  out_valid,
    output logic [2:0][QUO_W-1:0] out_quo,
    output logic [SB_W-1:0]       out_sb
);

    logic [QUO_W-1:0]        valid_reg;
    logic [2:0][DIST_W-1:0]  rem_reg [QUO_W];
    logic [2:0][QUO_W-1:0]   nq_reg  [QUO_W];
    logic [DIST_W-1:0]       den_reg [QUO_W];
    logic [SB_W-1:0]         sb_reg  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        logic                  v_in;
        logic [2:0][DIST_W-1:0] rem_in;
        logic [2:0][QUO_W-1:0]  nq_in;
        logic [DIST_W-1:0]      den_in;
        logic [SB_W-1:0]        sb_in;
        logic [2:0][DIST_W-1:0] rem_next;
        logic [2:0][QUO_W-1:0]  nq_next;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int j = 0; j < 3; j++)
                begin
                    rem_in[j] = in_num[j][NUM_W-1:QUO_W];
                    nq_in[j]  = in_num[j][QUO_W-1:0];
                end
            end
            assign v_in   = in_valid;
            assign den_in = in_den;
            assign sb_in  = in_sb;
        end
        else
        begin : g_later
            assign v_in   = valid_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign nq_in  = nq_reg[k-1];
            assign den_in = den_reg[k-1];
            assign sb_in  = sb_reg[k-1];
        end

        always_comb
        begin
            logic [DIST_W:0] t;
            logic [DIST_W:0] diff;
            logic            ge;
            for (int j = 0; j < 3; j++)
            begin
                t    = {rem_in[j], nq_in[j][QUO_W-1]};
                diff = t - {1'b0, den_in};
                ge   = (t >= {1'b0, den_in});
                rem_next[j] = ge ? diff[DIST_W-1:0] : t[DIST_W-1:0];
                nq_next[j]  = {nq_in[j][QUO_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                nq_reg[k]  <= nq_next;
                den_reg[k] <= den_in;
                sb_reg[k]  <= sb_in;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = nq_reg[QUO_W-1];
    assign out_sb    = sb_reg[QUO_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/sphere_pair_spring_contact_force.sv =====
// ---------------------------------------------------------------------------
// Sphere pair spring contact force
// Linear spring contact force between two spheres, fully pipelined.
// ---------------------------------------------------------------------------
// The block takes one sphere pair beat per cycle while pair_stall is low and
// returns one force beat per pair, in order. A beat passes through the
// offset and squared distance registers, the square root pipeline, the
// overlap and force product registers, the divider pipeline and the output
// register. A two entry output buffer lets the pipeline move one more beat
// while a result is held; stall on the pair channel rises only when that
// buffer is full.
`default_nettype none

module sphere_pair_spring_contact_force
    import spc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pair_valid,
    output logic    pair_stall,
    input  pair_t   pair,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int NUM_W  = PROD_W + DIST_W - FRAC_BITS - 1;
    localparam int QUO_W  = PROD_W - FRAC_BITS - 1;
    localparam int HALF_W = PROD_W / 2;
    localparam int PP_W   = HALF_W + DIST_W;
    localparam int FULL_W = PROD_W + DIST_W;
    localparam int CMP_W  = ((QUO_W > FORCE_W) ? QUO_W : FORCE_W) + 1;

    logic en;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg, s7_valid_reg;

    geo_side_t              s1_next;
    geo_side_t              s1_reg;
    logic [2:0][SQ_W-1:0]   sq2_reg;
    geo_side_t              s2_reg;
    logic [SQ_W-1:0]        sum3_reg;
    geo_side_t              s3_reg;

    logic                   sq_valid;
    logic [DIST_W-1:0]      sq_root;
    geo_side_t              sq_side;

    logic [DIST_W-1:0]      rsum_e;
    logic [DIST_W-1:0]      diff4;
    contact_status_t        status4_next;
    logic [OVL_W-1:0]       ovl4_reg;
    logic [KSUM_W-1:0]      ksum4_reg;
    logic [2:0][DIST_W-1:0] mag4_reg;
    logic [2:0]             neg4_reg;
    contact_status_t        status4_reg;
    logic [DIST_W-1:0]      root4_reg;

    logic [PROD_W-1:0]      p5_reg;
    logic [2:0][DIST_W-1:0] mag5_reg;
    logic [2:0]             neg5_reg;
    contact_status_t        status5_reg;
    logic [DIST_W-1:0]      root5_reg;

    logic [2:0][PP_W-1:0]   pl6_reg;
    logic [2:0][PP_W-1:0]   ph6_reg;
    logic [2:0]             neg6_reg;
    contact_status_t        status6_reg;
    logic [DIST_W-1:0]      root6_reg;

    logic [2:0][NUM_W-1:0]  num7_next;
    logic [2:0][NUM_W-1:0]  num7_reg;
    div_side_t              side7_reg;
    logic [DIST_W-1:0]      root7_reg;

    logic                   dv_valid;
    logic [2:0][QUO_W-1:0]  dv_quo;
    div_side_t              dv_side;

    result_t                fin;
    result_t                out_reg;
    result_t                skid_reg;
    logic                   out_valid_reg;
    logic                   skid_valid_reg;

    assign en         = !skid_valid_reg;
    assign pair_stall = skid_valid_reg;

    always_comb
    begin
        logic [2:0][DIST_W-1:0] off;
        off[0] = {pair.b_pos_x[COORD_W-1], pair.b_pos_x}
               - {pair.a_pos_x[COORD_W-1], pair.a_pos_x};
        off[1] = {pair.b_pos_y[COORD_W-1], pair.b_pos_y}
               - {pair.a_pos_y[COORD_W-1], pair.a_pos_y};
        off[2] = {pair.b_pos_z[COORD_W-1], pair.b_pos_z}
               - {pair.a_pos_z[COORD_W-1], pair.a_pos_z};
        for (int i = 0; i < 3; i++)
        begin
            s1_next.neg[i] = off[i][DIST_W-1];
            s1_next.mag[i] = off[i][DIST_W-1] ? (DIST_W'(0) - off[i]) : off[i];
        end
        s1_next.rsum = RSUM_W'(pair.a_radius) + RSUM_W'(pair.b_radius);
        s1_next.ksum = KSUM_W'(pair.a_stiffness) + KSUM_W'(pair.b_stiffness);
    end

    spc_sqrt #(
        .SB_W($bits(geo_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_sq     (sum3_reg),
        .in_sb     (s3_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_sb    (sq_side)
    );

    always_comb
    begin
        rsum_e = DIST_W'(sq_side.rsum);
        diff4  = rsum_e - sq_root;
        if (rsum_e <= sq_root)
        begin
            status4_next = ST_NONE;
        end
        else if (sq_root == '0)
        begin
            status4_next = ST_COINCIDENT;
        end
        else
        begin
            status4_next = ST_CONTACT;
        end
    end

    always_comb
    begin
        logic [FULL_W-1:0] full;
        for (int i = 0; i < 3; i++)
        begin
            full = {ph6_reg[i], {HALF_W{1'b0}}} + FULL_W'(pl6_reg[i]);
            num7_next[i] = full[FULL_W-1:FRAC_BITS+1];
        end
    end

    spc_div #(
        .FRAC_BITS (FRAC_BITS),
        .SB_W      ($bits(div_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s7_valid_reg),
        .in_num    (num7_reg),
        .in_den    (root7_reg),
        .in_sb     (side7_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_sb    (dv_side)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= pair_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= sq_valid;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;

            for (int i = 0; i < 3; i++)
            begin
                sq2_reg[i] <= s1_reg.mag[i] * s1_reg.mag[i];
            end
            s2_reg <= s1_reg;

            sum3_reg <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            s3_reg   <= s2_reg;

            ovl4_reg    <= diff4[OVL_W-1:0];
            ksum4_reg   <= sq_side.ksum;
            mag4_reg    <= sq_side.mag;
            neg4_reg    <= sq_side.neg;
            status4_reg <= status4_next;
            root4_reg   <= sq_root;

            p5_reg      <= ksum4_reg * ovl4_reg;
            mag5_reg    <= mag4_reg;
            neg5_reg    <= neg4_reg;
            status5_reg <= status4_reg;
            root5_reg   <= root4_reg;

            for (int i = 0; i < 3; i++)
            begin
                pl6_reg[i] <= p5_reg[HALF_W-1:0] * mag5_reg[i];
                ph6_reg[i] <= p5_reg[PROD_W-1:HALF_W] * mag5_reg[i];
            end
            neg6_reg    <= neg5_reg;
            status6_reg <= status5_reg;
            root6_reg   <= root5_reg;

            num7_reg         <= num7_next;
            side7_reg.neg    <= neg6_reg;
            side7_reg.status <= status6_reg;
            root7_reg        <= root6_reg;
        end
    end

    // The quotient magnitude is clamped against the positive or negative
    // limit according to the sign of the offset on that axis.
    always_comb
    begin
        logic [CMP_W-1:0]       q_e;
        logic [CMP_W-1:0]       neg_q;
        logic [2:0]             sat;
        logic [2:0][FORCE_W-1:0] f;
        for (int i = 0; i < 3; i++)
        begin
            q_e   = CMP_W'(dv_quo[i]);
            neg_q = CMP_W'(0) - q_e;
            if (dv_side.neg[i])
            begin
                sat[i] = (q_e > (CMP_W'(FORCE_MAX) + CMP_W'(1)));
                f[i]   = sat[i] ? FORCE_MIN : neg_q[FORCE_W-1:0];
            end
            else
            begin
                sat[i] = (q_e > CMP_W'(FORCE_MAX));
                f[i]   = sat[i] ? FORCE_MAX : q_e[FORCE_W-1:0];
            end
        end
        fin = '0;
        fin.contact_status = dv_side.status;
        if (dv_side.status == ST_CONTACT)
        begin
            fin.force_x   = f[0];
            fin.force_y   = f[1];
            fin.force_z   = f[2];
            fin.saturated = |sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !result_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= dv_valid;
            end
        end
        else if (dv_valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !result_stall)
        begin
            out_reg <= skid_valid_reg ? skid_reg : fin;
        end
        if (out_valid_reg && result_stall && !skid_valid_reg)
        begin
            skid_reg <= fin;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/spc_checker.sv =====
// ---------------------------------------------------------------------------
// Sphere pair contact force checker
// Port level assertions on the contact force block, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

module spc_checker
    import spc_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    pair_stall,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    // A held result beat stays presented.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result beat changed while stalled");

    // Without a valid contact the force is zero and nothing is clamped.
    a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.contact_status != ST_CONTACT) |->
            (result.force_x == '0) && (result.force_y == '0) &&
            (result.force_z == '0) && !result.saturated)
        else $error("nonzero force without contact");

    // Input stall only follows a held result beat.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pair_stall |-> $past(result_valid && result_stall))
        else $error("pair stall without a held result beat");

endmodule

bind sphere_pair_spring_contact_force spc_checker u_spc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pair_stall   (pair_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// Sphere pair spring contact force testbench
// Streams sphere pairs through the contact force pipeline with random idle
// cycles and stalls, predicts each force beat, and compares field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import spc_pkg::*;

    localparam int FRAC = 16;
    localparam int RANDOM_PAIRS = 1300;
    localparam int IDLE_LIMIT = 3000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    pair_valid = 1'b0;
    logic    pair_stall;
    pair_t   pair = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    pair_t   pending_pairs[$];
    result_t expected_forces[$];
    int      sent_count = 0;
    int      received_count = 0;
    int      send_gap = 0;
    int      recv_hold = 0;
    int      idle_cycles = 0;
    bit      failed = 1'b0;

    sphere_pair_spring_contact_force i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_stall   (pair_stall),
        .pair         (pair),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #1 clk = ~clk;

    function automatic result_t contact_force(pair_t p);
        logic signed [33:0] off[3];
        logic [33:0]        mag[3];
        logic [127:0]       sq;
        logic [127:0]       trial;
        logic [127:0]       num;
        logic [127:0]       quo;
        logic [63:0]        root;
        logic [65:0]        ovl;
        logic [65:0]        prod;
        logic [47:0]        f[3];
        result_t            r;
        off[0] = $signed({p.b_pos_x[31], p.b_pos_x}) - $signed({p.a_pos_x[31], p.a_pos_x});
        off[1] = $signed({p.b_pos_y[31], p.b_pos_y}) - $signed({p.a_pos_y[31], p.a_pos_y});
        off[2] = $signed({p.b_pos_z[31], p.b_pos_z}) - $signed({p.a_pos_z[31], p.a_pos_z});
        sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = off[i][33] ? -off[i] : off[i];
            sq = sq + 128'(mag[i]) * 128'(mag[i]);
        end
        root = '0;
        for (int b = 40; b >= 0; b--)
        begin
            trial = 128'(root | (64'd1 << b));
            if (trial * trial <= sq)
                root = trial[63:0];
        end
        ovl = 66'(p.a_radius) + 66'(p.b_radius) - 66'(root);
        r = '0;
        r.contact_status = ST_NONE;
        if (!ovl[65] && ovl != '0)
        begin
            if (root == '0)
                r.contact_status = ST_COINCIDENT;
            else
            begin
                prod = (66'(p.a_stiffness) + 66'(p.b_stiffness)) * ovl;
                for (int i = 0; i < 3; i++)
                begin
                    num = (128'(prod) * 128'(mag[i])) >> (FRAC + 1);
                    quo = num / 128'(root);
                    if (!off[i][33])
                    begin
                        if (quo > 128'(FORCE_MAX))
                        begin
                            f[i] = FORCE_MAX;
                            r.saturated = 1'b1;
                        end
                        else
                            f[i] = quo[47:0];
                    end
                    else if (quo > 128'(FORCE_MAX) + 128'd1)
                    begin
                        f[i] = FORCE_MIN;
                        r.saturated = 1'b1;
                    end
                    else
                        f[i] = -quo[47:0];
                end
                r.force_x = f[0];
                r.force_y = f[1];
                r.force_z = f[2];
                r.contact_status = ST_CONTACT;
            end
        end
        return r;
    endfunction

    function automatic pair_t random_pair(bit near);
        pair_t p;
        int    s;
        p.a_pos_x = $urandom;
        p.a_pos_y = $urandom;
        p.a_pos_z = $urandom;
        p.b_pos_x = $urandom;
        p.b_pos_y = $urandom;
        p.b_pos_z = $urandom;
        p.a_radius = 31'($urandom);
        p.b_radius = 31'($urandom);
        p.a_stiffness = 31'($urandom >> $urandom_range(0, 31));
        p.b_stiffness = 31'($urandom >> $urandom_range(0, 31));
        if (near)
        begin
            s = $urandom_range(2, 30);
            p.b_pos_x = p.a_pos_x + ($signed($urandom) >>> (32 - s));
            p.b_pos_y = p.a_pos_y + ($signed($urandom) >>> (32 - s));
            p.b_pos_z = p.a_pos_z + ($signed($urandom) >>> (32 - s));
            p.a_radius = 31'($urandom >> (32 - s));
            p.b_radius = 31'($urandom >> (32 - s));
        end
        return p;
    endfunction

    function automatic pair_t make_pair(int ax, int ay, int az, int bx, int by, int bz,
                                        int ra, int rb, int ka, int kb);
        pair_t p;
        p.a_pos_x = ax;
        p.a_pos_y = ay;
        p.a_pos_z = az;
        p.b_pos_x = bx;
        p.b_pos_y = by;
        p.b_pos_z = bz;
        p.a_radius = 31'(ra);
        p.b_radius = 31'(rb);
        p.a_stiffness = 31'(ka);
        p.b_stiffness = 31'(kb);
        return p;
    endfunction

    // Sender: a new beat is offered only once the previous one has been taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid <= 1'b0;
        end
        else
        begin
            if (pair_valid && !pair_stall)
            begin
                expected_forces.push_back(contact_force(pair));
                sent_count <= sent_count + 1;
            end
            if (!pair_valid || !pair_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    pair_valid <= 1'b0;
                end
                else if (pending_pairs.size() != 0)
                begin
                    pair <= pending_pairs.pop_front();
                    pair_valid <= 1'b1;
                    send_gap <= ((sent_count / 150) % 3 == 1) ? 0 : $urandom_range(0, 7);
                end
                else
                    pair_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each force beat and draws the stall before the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                int hold_n;
                received_count <= received_count + 1;
                if (expected_forces.size() == 0)
                begin
                    $display("%0t: unexpected force beat %p", $time, result);
                    failed = 1'b1;
                end
                else
                begin
                    result_t exp_r;
                    exp_r = expected_forces.pop_front();
                    if (result.force_x !== exp_r.force_x)
                    begin
                        $display("%0t: force_x expected %0d got %0d", $time,
                                 exp_r.force_x, result.force_x);
                        failed = 1'b1;
                    end
                    if (result.force_y !== exp_r.force_y)
                    begin
                        $display("%0t: force_y expected %0d got %0d", $time,
                                 exp_r.force_y, result.force_y);
                        failed = 1'b1;
                    end
                    if (result.force_z !== exp_r.force_z)
                    begin
                        $display("%0t: force_z expected %0d got %0d", $time,
                                 exp_r.force_z, result.force_z);
                        failed = 1'b1;
                    end
                    if (result.contact_status !== exp_r.contact_status)
                    begin
                        $display("%0t: contact_status expected %0d got %0d", $time,
                                 exp_r.contact_status, result.contact_status);
                        failed = 1'b1;
                    end
                    if (result.saturated !== exp_r.saturated)
                    begin
                        $display("%0t: saturated expected %0d got %0d", $time,
                                 exp_r.saturated, result.saturated);
                        failed = 1'b1;
                    end
                end
                if (received_count == 400)
                    hold_n = 300;
                else
                    hold_n = ((received_count / 150) % 3 == 2) ? 0 : $urandom_range(0, 7);
                if (hold_n != 0)
                begin
                    recv_hold <= hold_n - 1;
                    result_stall <= 1'b1;
                end
                else
                begin
                    recv_hold <= 0;
                    result_stall <= 1'b0;
                end
            end
            else if (recv_hold != 0)
            begin
                recv_hold <= recv_hold - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((pair_valid && !pair_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(5, 6, 7, 5, 6, 7, 65536, 1, 65536, 65536));
        pending_pairs.push_back(make_pair(0, 0, 0, 200000, 0, 0, 65536, 65536, 65536, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 65536, 0, 0, 65536, 65536, 131072, 65536));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, -65536, 0, 65536, 65536, 131072, 65536));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 1, 32'h7fffffff, 32'h7fffffff,
                                          32'h7fffffff, 32'h7fffffff));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, -1, 32'h7fffffff, 32'h7fffffff,
                                          32'h7fffffff, 32'h7fffffff));
        pending_pairs.push_back(make_pair(0, 0, 0, 1, -1, 1, 32'h7fffffff, 32'h7fffffff,
                                          32'h7fffffff, 32'h7fffffff));
        pending_pairs.push_back(make_pair(32'h80000000, 32'h80000000, 32'h80000000,
                                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                          32'h7fffffff));
        pending_pairs.push_back(make_pair(32'h7fffffff, 0, 0, 32'h80000000, 0, 0,
                                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                          32'h7fffffff));
        pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, 32'h7fffffff, 0, 5, 9));
        pending_pairs.push_back(make_pair(0, 0, 0, 3, 4, 0, 2, 3, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 3, 4, 0, 2, 4, 1, 0));
        pending_pairs.push_back(make_pair(100, 100, 100, 100, 100, 100, 0, 0, 7, 7));
        pending_pairs.push_back(make_pair(0, 0, 0, 100, -200, 300, 32'h7fffffff, 0, 1, 0));
        for (int i = 0; i < RANDOM_PAIRS; i++)
            pending_pairs.push_back(random_pair($urandom_range(0, 9) < 8));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (pending_pairs.size() == 0 && !pair_valid && expected_forces.size() == 0)
                break;
        end
        repeat (200) @(posedge clk);
        if (!failed && expected_forces.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
